### src/bfmd_pkg.sv
// shared constants and types of the decaying bloom filter
package bfmd_pkg;

    localparam int MAX_SLOTS_DEF  = 4096;
    localparam int MAX_HASHES_DEF = 4;
    localparam int SEED_REGS      = 4;

    // murmur3 constants
    localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2 = 32'h1b873593;
    localparam logic [31:0] MM_E  = 32'he6546b64;
    localparam logic [31:0] MM_F1 = 32'h85ebca6b;
    localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

    // action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_SLOTS  = 3'd0;
    localparam logic [2:0] REG_HASHES = 3'd1;
    localparam logic [2:0] REG_SEED0  = 3'd2;
    localparam logic [2:0] REG_SEED1  = 3'd3;
    localparam logic [2:0] REG_SEED2  = 3'd4;
    localparam logic [2:0] REG_SEED3  = 3'd5;

    localparam logic [7:0] LEVEL_FULL = 8'd255;

    // top level sequencer
    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_HASH,
        S_QCHK,
        S_DRD,
        S_DWR,
        S_RESP
    } t_state;

    // hash unit sequencer
    typedef enum logic [3:0] {
        H_IDLE,
        H_LO1,
        H_LO2,
        H_MIXLO,
        H_HI2,
        H_MIXHI,
        H_FM1,
        H_FM2,
        H_FM3,
        H_DIV,
        H_DONE
    } t_hstate;

endpackage

### src/bloom_filter_murmur3_decay_core.sv
// Bloom filter with per-slot decay levels keyed by a seeded murmur3 hash
//
// Each key is hashed with the enabled seeds in turn on one shared multiplier
// followed by a one-bit-per-cycle modulo and a done state. An insert sets
// each hashed slot as it goes; a query stops at the first clear flag, and a
// hit with decay then reads and rewrites each hashed slot before the
// response. A clear transaction, and reset, sweep the slot memory one entry
// per cycle, during which no transaction is accepted (configuration writes
// still are). One item is in work at a time; a new item can be taken while
// the last result waits.
module bloom_filter_murmur3_decay_core #(
    parameter int MAX_SLOTS  = bfmd_pkg::MAX_SLOTS_DEF,
    parameter int MAX_HASHES = bfmd_pkg::MAX_HASHES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic signed [31:0] i_key,
    input  logic        i_decay,
    input  logic [5:0]  i_window_k,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic [7:0]  o_level,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bfmd_pkg::*;

    localparam int SW = $clog2(MAX_SLOTS);
    localparam int MW = $clog2(MAX_SLOTS + 1);
    localparam int HL = (MAX_HASHES < SEED_REGS) ? MAX_HASHES : SEED_REGS;
    localparam int HW = (HL > 1) ? $clog2(HL) : 1;

    // configuration registers
    logic [12:0] r_slots;
    logic [2:0]  r_hashes;
    logic [31:0] r_seed [SEED_REGS];

    // sequencer state
    t_state        r_state, n_state;
    logic [SW-1:0] r_caddr, n_caddr;
    logic [HW-1:0] r_hcnt, n_hcnt;
    logic [HW-1:0] r_nm1, n_nm1;
    logic          r_start, n_start;
    logic          r_ins, n_ins;
    logic          r_dec, n_dec;
    logic [7:0]    r_thr, n_thr;
    logic [31:0]   r_lo, n_lo;
    logic [31:0]   r_hi, n_hi;
    logic [MW-1:0] r_mod, n_mod;
    logic          r_hitv, n_hitv;
    logic [7:0]    r_lvl, n_lvl;
    logic          r_ovalid, n_ovalid;
    logic          r_ohit, n_ohit;
    logic [7:0]    r_olvl, n_olvl;
    logic [SW-1:0] r_idx [HL];

    // slot memory: flag in bit 8, level below
    logic [8:0]    mem [MAX_SLOTS];
    logic [8:0]    r_rd;
    logic          mem_we;
    logic [SW-1:0] mem_addr;
    logic [8:0]    mem_wd;

    logic          idx_we;
    logic          cfg_wr;
    logic [2:0]    cfg_idx;
    logic          h_done;
    logic [SW-1:0] h_slot;
    logic [2:0]    eff_n;
    logic [MW-1:0] eff_mod;
    logic [7:0]    dec_lvl;
    logic          dec_clr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_hit   = r_ohit;
    assign o_level = r_olvl;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots   <= 13'd4096;
            r_hashes  <= 3'd4;
            r_seed[0] <= 32'd0;
            r_seed[1] <= 32'd1;
            r_seed[2] <= 32'd2;
            r_seed[3] <= 32'd3;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SLOTS:  r_slots   <= pwdata[12:0];
                REG_HASHES: r_hashes  <= pwdata[2:0];
                REG_SEED0:  r_seed[0] <= pwdata;
                REG_SEED1:  r_seed[1] <= pwdata;
                REG_SEED2:  r_seed[2] <= pwdata;
                REG_SEED3:  r_seed[3] <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // configuration read
    always_comb begin
        case (cfg_idx)
            REG_SLOTS:  prdata = {19'd0, r_slots};
            REG_HASHES: prdata = {29'd0, r_hashes};
            REG_SEED0:  prdata = r_seed[0];
            REG_SEED1:  prdata = r_seed[1];
            REG_SEED2:  prdata = r_seed[2];
            REG_SEED3:  prdata = r_seed[3];
            default:    prdata = 32'd0;
        endcase
    end

    // effective slot count and hash count
    always_comb begin
        if (r_slots == 13'd0) begin
            eff_mod = MW'(1);
        end else if ({19'd0, r_slots} > 32'(MAX_SLOTS)) begin
            eff_mod = MW'(MAX_SLOTS);
        end else begin
            eff_mod = MW'(r_slots);
        end
        if (r_hashes == 3'd0) begin
            eff_n = 3'd1;
        end else if (r_hashes > 3'(HL)) begin
            eff_n = 3'(HL);
        end else begin
            eff_n = r_hashes;
        end
    end

    // decay of the slot just read
    assign dec_clr = (r_rd[7:0] < r_thr);
    assign dec_lvl = dec_clr ? 8'd0 : (r_rd[7:0] - 8'd1);

    bfmd_hash #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_seed  (r_seed[2'(r_hcnt)]),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .i_mod   (r_mod),
        .o_done  (h_done),
        .o_slot  (h_slot)
    );

    // slot memory port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        r_rd <= mem[mem_addr];
    end

    // hashed slot list
    always_ff @(posedge i_clk) begin
        if (idx_we) begin
            r_idx[r_hcnt] <= h_slot;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_caddr  <= '0;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_caddr  <= n_caddr;
            r_start  <= n_start;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hcnt <= n_hcnt;
        r_nm1  <= n_nm1;
        r_ins  <= n_ins;
        r_dec  <= n_dec;
        r_thr  <= n_thr;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mod  <= n_mod;
        r_hitv <= n_hitv;
        r_lvl  <= n_lvl;
        r_ohit <= n_ohit;
        r_olvl <= n_olvl;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_caddr  = r_caddr;
        n_hcnt   = r_hcnt;
        n_nm1    = r_nm1;
        n_start  = 1'b0;
        n_ins    = r_ins;
        n_dec    = r_dec;
        n_thr    = r_thr;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mod    = r_mod;
        n_hitv   = r_hitv;
        n_lvl    = r_lvl;
        n_ovalid = r_ovalid && !i_ready;
        n_ohit   = r_ohit;
        n_olvl   = r_olvl;
        mem_we   = 1'b0;
        mem_addr = r_idx[r_hcnt];
        mem_wd   = {1'b1, dec_lvl};
        idx_we   = 1'b0;
        case (r_state)
            S_CLR: begin
                mem_we   = 1'b1;
                mem_addr = r_caddr;
                mem_wd   = 9'd0;
                n_caddr  = r_caddr + SW'(1);
                if (r_caddr == SW'(MAX_SLOTS - 1)) begin
                    n_caddr = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    // sign-extended key byte-swapped: low word is the sign fill
                    n_lo   = {32{i_key[31]}};
                    n_hi   = {i_key[7:0], i_key[15:8], i_key[23:16], i_key[31:24]};
                    n_mod  = eff_mod;
                    n_nm1  = HW'(eff_n - 3'd1);
                    n_hcnt = '0;
                    n_ins  = (i_action == ACT_INSERT);
                    n_dec  = i_decay;
                    n_thr  = 8'd253 - {i_window_k, 2'b00};
                    case (i_action)
                        ACT_INSERT, ACT_QUERY: begin
                            n_start = 1'b1;
                            n_state = S_HASH;
                        end
                        ACT_CLEAR: begin
                            n_caddr = '0;
                            n_state = S_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HASH: begin
                mem_addr = h_slot;
                mem_wd   = {1'b1, LEVEL_FULL};
                if (h_done) begin
                    idx_we = 1'b1;
                    if (r_ins) begin
                        mem_we = 1'b1;
                        if (r_hcnt == r_nm1) begin
                            n_state = S_IDLE;
                        end else begin
                            n_hcnt  = r_hcnt + HW'(1);
                            n_start = 1'b1;
                        end
                    end else begin
                        n_state = S_QCHK;
                    end
                end
            end
            S_QCHK: begin
                if (!r_rd[8]) begin
                    n_hitv  = 1'b0;
                    n_lvl   = 8'd0;
                    n_state = S_RESP;
                end else if (r_hcnt != r_nm1) begin
                    n_hcnt  = r_hcnt + HW'(1);
                    n_start = 1'b1;
                    n_state = S_HASH;
                end else if (r_dec) begin
                    n_hitv  = 1'b1;
                    n_hcnt  = '0;
                    n_state = S_DRD;
                end else begin
                    n_hitv  = 1'b1;
                    n_lvl   = r_rd[7:0];
                    n_state = S_RESP;
                end
            end
            S_DRD: begin
                n_state = S_DWR;
            end
            S_DWR: begin
                // read-modify-write in hash order so repeated slots decay twice
                mem_we = 1'b1;
                mem_wd = {!dec_clr, dec_lvl};
                n_lvl  = dec_lvl;
                if (r_hcnt == r_nm1) begin
                    n_state = S_RESP;
                end else begin
                    n_hcnt  = r_hcnt + HW'(1);
                    n_state = S_DRD;
                end
            end
            S_RESP: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_ohit   = r_hitv;
                    n_olvl   = r_lvl;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### src/bfmd_hash.sv
// murmur3 hash of one key with one seed on a shared multiplier, then bit-serial modulo
module bfmd_hash #(
    parameter int MAX_SLOTS = bfmd_pkg::MAX_SLOTS_DEF,
    localparam int SW = $clog2(MAX_SLOTS),
    localparam int MW = $clog2(MAX_SLOTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_seed,
    input  logic [31:0]   i_lo,
    input  logic [31:0]   i_hi,
    input  logic [MW-1:0] i_mod,
    output logic          o_done,
    output logic [SW-1:0] o_slot
);
    import bfmd_pkg::*;

    t_hstate       r_state, n_state;
    logic [31:0]   r_h, n_h;
    logic [31:0]   r_b, n_b;
    logic [MW-1:0] r_rem, n_rem;
    logic [4:0]    r_cnt, n_cnt;

    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] rot15b, mix_x, mix_r, mix_v, fm_y, fm_v;
    logic [MW:0] trial, modx;

    // shared multiplier, low word only
    assign prod = mul_a * mul_b;

    // block rotate and state mix
    assign rot15b = {r_b[16:0], r_b[31:17]};
    assign mix_x  = r_h ^ r_b;
    assign mix_r  = {mix_x[18:0], mix_x[31:19]};
    assign mix_v  = (mix_r << 2) + mix_r + MM_E;
    assign fm_y   = r_h ^ 32'd8;
    assign fm_v   = fm_y ^ (fm_y >> 16);

    // one restoring division step
    assign trial = {r_rem, r_h[31]};
    assign modx  = {1'b0, i_mod};

    assign o_done = (r_state == H_DONE);
    assign o_slot = r_rem[SW-1:0];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_h   <= n_h;
        r_b   <= n_b;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    // sequencer and datapath control
    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_b     = r_b;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        mul_a   = 32'd0;
        mul_b   = 32'd0;
        case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    n_h     = i_seed;
                    n_state = H_LO1;
                end
            end
            H_LO1: begin
                mul_a   = i_lo;
                mul_b   = MM_C1;
                n_b     = prod;
                n_state = H_LO2;
            end
            H_LO2: begin
                mul_a   = rot15b;
                mul_b   = MM_C2;
                n_b     = prod;
                n_state = H_MIXLO;
            end
            H_MIXLO: begin
                n_h     = mix_v;
                mul_a   = i_hi;
                mul_b   = MM_C1;
                n_b     = prod;
                n_state = H_HI2;
            end
            H_HI2: begin
                mul_a   = rot15b;
                mul_b   = MM_C2;
                n_b     = prod;
                n_state = H_MIXHI;
            end
            H_MIXHI: begin
                n_h     = mix_v;
                n_state = H_FM1;
            end
            H_FM1: begin
                mul_a   = fm_v;
                mul_b   = MM_F1;
                n_h     = prod;
                n_state = H_FM2;
            end
            H_FM2: begin
                mul_a   = r_h ^ (r_h >> 13);
                mul_b   = MM_F2;
                n_h     = prod;
                n_state = H_FM3;
            end
            H_FM3: begin
                n_h     = r_h ^ (r_h >> 16);
                n_rem   = '0;
                n_cnt   = 5'd0;
                n_state = H_DIV;
            end
            H_DIV: begin
                if (trial >= modx) begin
                    n_rem = MW'(trial - modx);
                end else begin
                    n_rem = trial[MW-1:0];
                end
                n_h   = r_h << 1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = H_DONE;
                end
            end
            H_DONE: begin
                n_state = H_IDLE;
            end
            default: begin
                n_state = H_IDLE;
            end
        endcase
    end

endmodule

### test/tb_bloom_filter_murmur3_decay_core.sv
// testbench for the decaying murmur3 bloom filter core
`timescale 1ns / 1ps

module tb_bloom_filter_murmur3_decay_core;
    import bfmd_pkg::*;

    localparam int NSLOT = MAX_SLOTS_DEF;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key;
        logic        decay;
        logic [5:0]  window_k;
    } t_item;

    typedef struct packed {
        logic       hit;
        logic [7:0] level;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_action = '0;
    logic signed [31:0] i_key = '0;
    logic        i_decay = 1'b0;
    logic [5:0]  i_window_k = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_hit;
    logic [7:0]  o_level;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bloom_filter_murmur3_decay_core dut (.*);

    always #5 i_clk = ~i_clk;

    // filter shadow state and configuration
    logic        shadow_flag [NSLOT];
    logic [7:0]  shadow_level [NSLOT];
    logic [12:0] cfg_slots = 13'd4096;
    logic [2:0]  cfg_hashes = 3'd4;
    logic [31:0] cfg_seed [4] = '{32'd0, 32'd1, 32'd2, 32'd3};

    t_item   pending_items[$];
    t_answer expected_answers[$];
    int      fail_count = 0;
    int      accepted_count = 0;
    int      hold_off_cycles = 0;

    function automatic logic [31:0] rotl(logic [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] mix_block(logic [31:0] blk, logic [31:0] h);
        blk = blk * MM_C1;
        blk = rotl(blk, 15);
        blk = blk * MM_C2;
        h = h ^ blk;
        h = rotl(h, 13);
        return h * 32'd5 + MM_E;
    endfunction

    // append one item to the send queue
    function automatic void queue_item(t_item it);
        pending_items = {pending_items, it};
    endfunction

    // murmur3 slot index of a key for one seed
    function automatic int slot_index(logic [31:0] key, int n);
        logic [63:0] ext;
        logic [63:0] swapped;
        logic [31:0] h;
        int          s;
        ext = {{32{key[31]}}, key};
        for (int b = 0; b < 8; b++) swapped[8*b +: 8] = ext[8*(7-b) +: 8];
        h = cfg_seed[n];
        h = mix_block(swapped[31:0], h);
        h = mix_block(swapped[63:32], h);
        h = h ^ 32'd8;
        h = h ^ (h >> 16);
        h = h * MM_F1;
        h = h ^ (h >> 13);
        h = h * MM_F2;
        h = h ^ (h >> 16);
        s = (cfg_slots == 0) ? 1 : ((cfg_slots > NSLOT) ? NSLOT : cfg_slots);
        return int'(h % s);
    endfunction

    // apply one transaction to the shadow filter, queue the answer of a query
    function automatic void predict_filter(t_item it);
        int      n;
        int      idx;
        int      thr;
        t_answer ans;
        n = (cfg_hashes == 0) ? 1 : ((cfg_hashes > 4) ? 4 : cfg_hashes);
        idx = 0;
        case (it.action)
            ACT_INSERT: begin
                for (int i = 0; i < n; i++) begin
                    idx = slot_index(it.key, i);
                    shadow_flag[idx] = 1'b1;
                    shadow_level[idx] = LEVEL_FULL;
                end
            end
            ACT_CLEAR: begin
                for (int s = 0; s < NSLOT; s++) begin
                    shadow_flag[s] = 1'b0;
                    shadow_level[s] = '0;
                end
            end
            ACT_QUERY: begin
                ans.hit = 1'b1;
                for (int i = 0; i < n && ans.hit; i++) begin
                    idx = slot_index(it.key, i);
                    if (!shadow_flag[idx]) ans.hit = 1'b0;
                end
                if (ans.hit && it.decay) begin
                    thr = 255 - 2 * (2 * it.window_k + 1);
                    for (int i = 0; i < n; i++) begin
                        idx = slot_index(it.key, i);
                        if (int'(shadow_level[idx]) < thr) begin
                            shadow_flag[idx] = 1'b0;
                            shadow_level[idx] = '0;
                        end else begin
                            shadow_level[idx] = shadow_level[idx] - 8'd1;
                        end
                    end
                end
                ans.level = ans.hit ? shadow_level[idx] : 8'd0;
                expected_answers = {expected_answers, ans};
            end
            default: ;
        endcase
    endfunction

    // handshakes seen at the last rising edge
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && i_valid && o_ready;
        out_fire <= i_rst_n && o_valid && i_ready;
    end

    // item driver
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_fire) begin
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            i_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
            i_valid <= 1'b1;
            {i_action, i_key, i_decay, i_window_k} <= pending_items.pop_front();
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // result ready with random stalls and a long hold-off when asked
    int recv_gap = 0;
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (out_fire)
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        end
    end

    // monitor: predict on item transactions, check result transactions
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && i_valid && o_ready) begin
            predict_filter({i_action, i_key, i_decay, i_window_k});
            accepted_count <= accepted_count + 1;
        end
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_hit, o_level};
            if (expected_answers.size() == 0) begin
                $error("unexpected result hit=%0d level=%0d", o_hit, o_level);
                fail_count++;
            end else begin
                want = expected_answers.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d actual %0d", want.hit, got.hit);
                    fail_count++;
                end
                if (got.level !== want.level) begin
                    $error("level: expected %0d actual %0d", want.level, got.level);
                    fail_count++;
                end
            end
        end
    end

    task automatic reg_write(logic [2:0] index, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (index)
            REG_SLOTS:  cfg_slots = value[12:0];
            REG_HASHES: cfg_hashes = value[2:0];
            REG_SEED0, REG_SEED1, REG_SEED2, REG_SEED3: cfg_seed[index - REG_SEED0] = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // wait for all sent items to be accepted, finished and answered
    task automatic drain(int total);
        while (accepted_count < total || expected_answers.size() > 0 || i_valid || !o_ready)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic t_item make_item(logic [1:0] a, logic [31:0] k, logic d, logic [5:0] w);
        t_item it;
        it.action = a;
        it.key = k;
        it.decay = d;
        it.window_k = w;
        return it;
    endfunction

    // random phase with a small key pool so queries mostly hit
    task automatic random_phase(int count, ref int total);
        logic [31:0] pool [8];
        int          r;
        logic [1:0]  a;
        for (int i = 0; i < 8; i++) pool[i] = $urandom();
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35) a = ACT_INSERT;
            else if (r < 95) a = ACT_QUERY;
            else if (r < 97) a = ACT_CLEAR;
            else a = 2'd3;
            queue_item(make_item(a,
                ($urandom_range(0, 4) == 0) ? $urandom() : pool[$urandom_range(0, 7)],
                $urandom_range(0, 1), $urandom_range(0, 63)));
        end
        total += count;
    endtask

    int sent_total = 0;
    initial begin
        for (int s = 0; s < NSLOT; s++) begin
            shadow_flag[s] = 1'b0;
            shadow_level[s] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes of keys, all actions, miss, repeated decay, unknown action
        queue_item(make_item(ACT_QUERY, 32'h0000_0000, 1'b1, 6'd0));
        queue_item(make_item(ACT_INSERT, 32'h7fff_ffff, 1'b0, 6'd63));
        queue_item(make_item(ACT_INSERT, 32'h8000_0000, 1'b1, 6'd0));
        queue_item(make_item(ACT_INSERT, 32'hffff_ffff, 1'b0, 6'd0));
        queue_item(make_item(ACT_QUERY, 32'h7fff_ffff, 1'b0, 6'd0));
        queue_item(make_item(ACT_QUERY, 32'h8000_0000, 1'b1, 6'd63));
        queue_item(make_item(ACT_QUERY, 32'h8000_0000, 1'b1, 6'd0));
        queue_item(make_item(ACT_QUERY, 32'hffff_ffff, 1'b1, 6'd63));
        queue_item(make_item(2'd3, 32'h7fff_ffff, 1'b1, 6'd0));
        queue_item(make_item(ACT_QUERY, 32'h7fff_ffff, 1'b1, 6'd31));
        queue_item(make_item(ACT_CLEAR, 32'h0, 1'b0, 6'd0));
        queue_item(make_item(ACT_QUERY, 32'h7fff_ffff, 1'b0, 6'd0));
        sent_total += 12;
        drain(sent_total);

        // tiny filter: one slot forces repeated-slot decay, zero hash count
        reg_write(REG_SLOTS, 32'd1);
        reg_write(REG_HASHES, 32'd4);
        queue_item(make_item(ACT_INSERT, 32'd5, 1'b0, 6'd0));
        for (int i = 0; i < 6; i++)
            queue_item(make_item(ACT_QUERY, $urandom(), 1'b1, 6'd0));
        sent_total += 7;
        drain(sent_total);
        reg_write(REG_SLOTS, 32'd0);
        reg_write(REG_HASHES, 32'd0);
        queue_item(make_item(ACT_QUERY, 32'd9, 1'b1, 6'd63));
        queue_item(make_item(ACT_QUERY, 32'd9, 1'b1, 6'd63));
        sent_total += 2;
        drain(sent_total);

        // oversized settings saturate; unknown register index ignored
        reg_write(REG_SLOTS, 32'h1fff);
        reg_write(REG_HASHES, 32'd7);
        reg_write(3'd6, 32'hffff_ffff);
        reg_write(3'd7, 32'h0);
        reg_write(REG_SEED0, 32'hffff_ffff);
        reg_write(REG_SEED1, 32'h0);
        reg_write(REG_SEED2, $urandom());
        reg_write(REG_SEED3, $urandom());

        // long receiver hold-off while the sender keeps offering
        hold_off_cycles = 3000;
        random_phase(30, sent_total);
        drain(sent_total);

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin reg_write(REG_SLOTS, 32'd4096); reg_write(REG_HASHES, 32'd1); end
                1: begin reg_write(REG_SLOTS, 32'd2); reg_write(REG_HASHES, 32'd3); end
                2: begin reg_write(REG_SLOTS, $urandom_range(1, 64)); reg_write(REG_HASHES, 32'd2); end
                3: begin reg_write(REG_SLOTS, $urandom_range(1, 4096)); reg_write(REG_HASHES, 32'd4); end
                4: begin reg_write(REG_SLOTS, 32'd4096); reg_write(REG_HASHES, 32'd4); end
                default: begin reg_write(REG_SLOTS, 32'd17); reg_write(REG_HASHES, 32'd4); end
            endcase
            reg_write(REG_SEED0, $urandom());
            reg_write(REG_SEED1, $urandom());
            random_phase(160, sent_total);
            drain(sent_total);
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // run-time limit
    initial begin
        #(60_000_000);
        $display("Regression FAIL");
        $finish;
    end
endmodule
